// ===== rtl/mpd_pkg.sv =====
package mpd_pkg;

    localparam int MAX_LEVELS    = 10;
    localparam int LEVELS_W      = 4;
    localparam int INDEX_W       = 11;
    localparam int SAMPLE_W      = 16;
    localparam int HEIGHT_W      = 17;
    localparam int HEIGHTS_DEPTH = (1 << MAX_LEVELS) + 1;
    localparam int OUT_TDATA_W   = 32;

    localparam logic [LEVELS_W-1:0] LEVELS_RESET = LEVELS_W'(MAX_LEVELS);

    localparam logic signed [HEIGHT_W:0] HEIGHT_MAX = (HEIGHT_W+1)'((1 << (HEIGHT_W-1)) - 1);
    localparam logic signed [HEIGHT_W:0] HEIGHT_MIN = -(HEIGHT_W+1)'(1 << (HEIGHT_W-1));

    // endpoint phase codes
    localparam logic [1:0] EP_LEFT  = 2'd0;
    localparam logic [1:0] EP_RIGHT = 2'd1;
    localparam logic [1:0] EP_DONE  = 2'd2;

    typedef logic [INDEX_W-1:0]         t_index;
    typedef logic signed [HEIGHT_W-1:0] t_height;

    function automatic logic [LEVELS_W-1:0] eff_levels(input logic [LEVELS_W-1:0] lv);
        logic [LEVELS_W-1:0] l;
        l = lv;
        if (l < LEVELS_W'(1)) begin
            l = LEVELS_W'(1);
        end
        if (l > LEVELS_W'(MAX_LEVELS)) begin
            l = LEVELS_W'(MAX_LEVELS);
        end
        return l;
    endfunction

endpackage

// ===== rtl/midpoint_displacement_1d.sv =====
// One-dimensional midpoint-displacement profile generator. Each transfer on the slave side
// carries one signed Q1.15 random sample; the first two set the end points at index 0 and
// 2^levels, every later one fills the next midpoint, level by level and left to right, with
// the floored average of the segment ends plus the sample shifted right by level+1. Each
// sample yields one result: point index, Q2.15 height and tlast on the final point, after
// which a new profile starts. The block takes one sample per cycle when the master side is
// not stalled; a sample passes the read stage, then the output register. Heights live in a
// 1025-entry memory with two read ports and one write port; a midpoint that depends on the
// height written just before it is forwarded from the output register. Writing levels
// restarts the profile and keeps the stored heights. The memory is not cleared at reset.
module midpoint_displacement_1d
    import mpd_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_wr_en,
    input  logic [LEVELS_W-1:0]    i_cfg_wr_data,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [SAMPLE_W-1:0]    s_axis_tdata,   // [15:0] random_sample
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [10:0] point_index, [27:11] point_value
    output logic                   m_axis_tlast    // last_point
);

    logic [LEVELS_W-1:0] r_levels;
    logic [LEVELS_W-1:0] r_level;
    t_index              r_seg_start;
    t_index              r_seg_step;
    logic [1:0]          r_ep;

    logic [LEVELS_W-1:0] n_level;
    t_index              n_seg_start;
    t_index              n_seg_step;
    logic [1:0]          n_ep;

    logic                    r_s1_valid;
    logic                    r_s1_mid;
    t_index                  r_s1_idx;
    logic signed [SAMPLE_W-1:0] r_s1_disp;
    logic                    r_s1_last;
    logic                    r_s1_fwd_a;
    logic                    r_s1_fwd_b;
    t_height                 r_rd_a;
    t_height                 r_rd_b;

    logic    r_out_valid;
    t_index  r_out_index;
    t_height r_out_value;
    logic    r_out_last;

    t_height r_mem [0:HEIGHTS_DEPTH-1];

    logic [LEVELS_W-1:0] eff_l;
    t_index              last_idx;
    t_index              step_c;
    t_index              j_c;
    t_index              k_c;
    logic [INDEX_W:0]    jk_sum;
    logic [INDEX_W:0]    k_wide;
    t_index              idx_c;
    logic                is_last_c;
    logic                mid_c;
    logic [LEVELS_W:0]   shift_c;
    logic signed [SAMPLE_W-1:0] sample_c;
    logic signed [SAMPLE_W-1:0] disp_c;

    logic in_xfer;
    logic s1_move;

    t_height              h_a;
    t_height              h_b;
    logic signed [HEIGHT_W:0] avg_c;
    logic signed [HEIGHT_W:0] sum_c;
    t_height              val_c;

    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign s1_move       = r_s1_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_s1_valid || s1_move;

    assign eff_l    = eff_levels(r_levels);
    assign last_idx = INDEX_W'(1) << eff_l;
    assign sample_c = $signed(s_axis_tdata);
    assign shift_c  = {1'b0, r_level} + (LEVELS_W+1)'(1);
    assign disp_c   = sample_c >>> shift_c;

    // segment selection and sequencer advance
    always_comb begin
        step_c = r_seg_step;
        if (step_c < INDEX_W'(2) || step_c > last_idx) begin
            step_c = INDEX_W'(2);
        end
        j_c    = r_seg_start;
        jk_sum = {1'b0, j_c} + {1'b0, step_c};
        if (jk_sum > {1'b0, last_idx}) begin
            j_c = '0;
        end
        k_wide = {1'b0, j_c} + {1'b0, step_c};
        k_c    = k_wide[INDEX_W-1:0];

        n_level     = r_level;
        n_seg_start = r_seg_start;
        n_seg_step  = r_seg_step;
        n_ep        = r_ep;
        is_last_c   = 1'b0;
        mid_c       = 1'b0;
        idx_c       = '0;

        case (r_ep)
            EP_LEFT: begin
                idx_c = '0;
                n_ep  = EP_RIGHT;
            end
            EP_RIGHT: begin
                idx_c = last_idx;
                n_ep  = EP_DONE;
            end
            default: begin
                mid_c = 1'b1;
                idx_c = j_c + (step_c >> 1);
                if (k_wide >= {1'b0, last_idx}) begin
                    if (({1'b0, r_level} + (LEVELS_W+1)'(1)) >= {1'b0, eff_l}) begin
                        is_last_c   = 1'b1;
                        n_level     = '0;
                        n_seg_start = '0;
                        n_seg_step  = last_idx;
                        n_ep        = EP_LEFT;
                    end else begin
                        n_level     = r_level + LEVELS_W'(1);
                        n_seg_start = '0;
                        n_seg_step  = step_c >> 1;
                    end
                end else begin
                    n_seg_start = k_c;
                    n_seg_step  = step_c;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_levels    <= LEVELS_RESET;
            r_level     <= '0;
            r_seg_start <= '0;
            r_seg_step  <= INDEX_W'(1) << eff_levels(LEVELS_RESET);
            r_ep        <= EP_LEFT;
        end else if (i_cfg_wr_en) begin
            r_levels    <= i_cfg_wr_data;
            r_level     <= '0;
            r_seg_start <= '0;
            r_seg_step  <= INDEX_W'(1) << eff_levels(i_cfg_wr_data);
            r_ep        <= EP_LEFT;
        end else if (in_xfer) begin
            r_level     <= n_level;
            r_seg_start <= n_seg_start;
            r_seg_step  <= n_seg_step;
            r_ep        <= n_ep;
        end
    end

    // read stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_xfer) begin
            r_s1_valid <= 1'b1;
        end else if (s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1_mid   <= mid_c;
            r_s1_idx   <= idx_c;
            r_s1_disp  <= mid_c ? disp_c : sample_c;
            r_s1_last  <= is_last_c;
            r_s1_fwd_a <= s1_move && (j_c == r_s1_idx);
            r_s1_fwd_b <= s1_move && (k_c == r_s1_idx);
        end
    end

    // height memory
    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_mem[r_s1_idx] <= val_c;
        end
        if (in_xfer) begin
            r_rd_a <= r_mem[j_c];
            r_rd_b <= r_mem[k_c];
        end
    end

    // midpoint value
    always_comb begin
        h_a   = r_s1_fwd_a ? r_out_value : r_rd_a;
        h_b   = r_s1_fwd_b ? r_out_value : r_rd_b;
        avg_c = $signed({h_a[HEIGHT_W-1], h_a} + {h_b[HEIGHT_W-1], h_b}) >>> 1;
        sum_c = avg_c + (HEIGHT_W+1)'(r_s1_disp);
        if (!r_s1_mid) begin
            val_c = t_height'(r_s1_disp);
        end else if (sum_c > HEIGHT_MAX) begin
            val_c = HEIGHT_MAX[HEIGHT_W-1:0];
        end else if (sum_c < HEIGHT_MIN) begin
            val_c = HEIGHT_MIN[HEIGHT_W-1:0];
        end else begin
            val_c = sum_c[HEIGHT_W-1:0];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_move) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_out_index <= r_s1_idx;
            r_out_value <= val_c;
            r_out_last  <= r_s1_last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {(OUT_TDATA_W-INDEX_W-HEIGHT_W)'(0), r_out_value, r_out_index};
    assign m_axis_tlast  = r_out_last;

endmodule
